// ===== src/nur_pkg.sv =====
// Shared types and constants of the nearest-neighbor upsampler with requantization.
// No dependencies; imported by every module of the block except nur_ram.
package nur_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_MODE        = 3'd0;
	localparam logic [2:0] REG_IN_WIDTH    = 3'd1;
	localparam logic [2:0] REG_IN_HEIGHT   = 3'd2;
	localparam logic [2:0] REG_RECIP_SCALE = 3'd3;
	localparam logic [2:0] REG_IN_ZERO_PT  = 3'd4;
	localparam logic [2:0] REG_OUT_ZERO_PT = 3'd5;
	localparam logic [2:0] REG_REQUANT     = 3'd6;

	localparam int CFG_DATA_W = 24;

	// Item kinds on the input tuser.
	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	// Output modes.
	localparam logic MODE_RAW   = 1'b0;
	localparam logic MODE_QUANT = 1'b1;

	localparam logic [7:0] QMAX = 8'd255;

	typedef struct packed {
		logic        mode;
		logic [8:0]  in_width;
		logic [8:0]  in_height;
		logic [16:0] recip_scale_q16;
		logic [7:0]  in_zero_pt;
		logic [7:0]  out_zero_pt;
		logic [23:0] requant_mult_q16;
	} cfg_t;

endpackage

// ===== src/nearest_upsample_requant_core.sv =====
// Nearest-neighbor 2D upsampler over one plane store, with optional uint8 requantization.
// Results pass the front, store, multiply and output registers; loads give none.
// Throughput: one item per cycle; the whole pipe stalls only while a result waits on m_axis.
// Reset: arst_n clears the pipeline valid bits and loads the register reset values.
// The plane store is not cleared; entries read before being written are undefined.
// Depends on nur_pkg, nur_map, nur_ram, nur_requant.
module nearest_upsample_requant_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int ELEM_BITS  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_wr_en,
	input  logic [2:0]                        cfg_addr,
	input  logic [nur_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// input items
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [55:0]                       s_axis_tdata,  // pos_row, pos_col, elem_value, pad
	input  logic                              s_axis_tuser,  // req_type
	// result items
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [31:0]                       m_axis_tdata,  // out_value
	output logic                              m_axis_tuser   // clamped
);
	import nur_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cfg_t cfg_q;

	logic                 adv;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [ELEM_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [ELEM_BITS-1:0] ram_rdata;
	logic                 rd_valid_s2;

	// Register file, read live by the pipe: the user writes only while idle; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode             <= MODE_QUANT;
			cfg_q.in_width         <= 9'd256;
			cfg_q.in_height        <= 9'd256;
			cfg_q.recip_scale_q16  <= 17'd32768;
			cfg_q.in_zero_pt       <= 8'd0;
			cfg_q.out_zero_pt      <= 8'd0;
			cfg_q.requant_mult_q16 <= 24'd65536;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_MODE:        cfg_q.mode             <= cfg_wdata[0];
				REG_IN_WIDTH:    cfg_q.in_width         <= cfg_wdata[8:0];
				REG_IN_HEIGHT:   cfg_q.in_height        <= cfg_wdata[8:0];
				REG_RECIP_SCALE: cfg_q.recip_scale_q16  <= cfg_wdata[16:0];
				REG_IN_ZERO_PT:  cfg_q.in_zero_pt       <= cfg_wdata[7:0];
				REG_OUT_ZERO_PT: cfg_q.out_zero_pt      <= cfg_wdata[7:0];
				REG_REQUANT:     cfg_q.requant_mult_q16 <= cfg_wdata;
				default: ;  // unknown index: drop the write
			endcase
		end
	end

	// Advance every stage together whenever the output register is free or being drained.
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// Stage 1: coordinate products; address and store access issue at its output.
	nur_map #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.ELEM_BITS (ELEM_BITS),
		.AW        (AW)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser),
		.in_row   (s_axis_tdata[10:0]),
		.in_col   (s_axis_tdata[21:11]),
		.in_value (s_axis_tdata[53:22]),
		.cfg      (cfg_q),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr)
	);

	// Stage 2: the plane store. Loads and requests touch it in item order at the same
	// stage, so a request always sees every earlier load without extra forwarding.
	nur_ram #(
		.WIDTH(ELEM_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Track which store reads carry a request result; loads drop out here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s2 <= 1'b0;
		end else if (adv) begin
			rd_valid_s2 <= ram_re;
		end
	end

	// Stages 3 and 4: requantize multiply, then round, offset, clamp into the output register.
	nur_requant #(
		.ELEM_BITS(ELEM_BITS)
	) u_requant (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.rd_valid   (rd_valid_s2),
		.rd_elem    (ram_rdata),
		.cfg        (cfg_q),
		.out_valid  (m_axis_tvalid),
		.out_value  (m_axis_tdata),
		.out_clamped(m_axis_tuser)
	);

	// One item sits in the front stage at a time, so the store never sees a read and a
	// write in the same cycle.
	a_store_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store read and write issued in the same cycle");

	// A store read is only issued when the pipe advances, so its data is never overwritten
	// before stage 3 takes it.
	a_read_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> adv)
		else $error("store read issued during a stall");

	// Raw mode never reports saturation.
	a_raw_no_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (cfg_q.mode == MODE_RAW)) |-> !m_axis_tuser)
		else $error("clamp flag set in raw mode");

	// Requantized results fit in one byte.
	a_quant_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (cfg_q.mode == MODE_QUANT)) |-> (m_axis_tdata[31:8] == 24'd0))
		else $error("requantized result exceeds one byte");

endmodule

// ===== src/nur_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module nur_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/nur_map.sv =====
// Front stage: registers the item with the source coordinate products, then clamps request
// coordinates, drops loads outside the plane and forms the store address. Depends on nur_pkg.
module nur_map #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int ELEM_BITS  = 32,
	parameter int AW         = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic                 in_kind,
	input  logic [10:0]          in_row,
	input  logic [10:0]          in_col,
	input  logic [31:0]          in_value,
	input  nur_pkg::cfg_t        cfg,
	output logic                 ram_we,
	output logic [AW-1:0]        ram_waddr,
	output logic [ELEM_BITS-1:0] ram_wdata,
	output logic                 ram_re,
	output logic [AW-1:0]        ram_raddr
);
	import nur_pkg::*;

	localparam logic [12:0] MAXW_C = 13'(MAX_WIDTH);
	localparam logic [12:0] MAXH_C = 13'(MAX_HEIGHT);

	logic                 valid_s1;
	logic                 kind_s1;
	logic [10:0]          row_s1;
	logic [10:0]          col_s1;
	logic [ELEM_BITS-1:0] value_s1;
	logic [27:0]          prod_row_s1;
	logic [27:0]          prod_col_s1;

	logic [8:0]  eff_w;
	logic [8:0]  eff_h;
	logic [11:0] src_row;
	logic [11:0] src_col;
	logic [11:0] map_row;
	logic [11:0] map_col;
	logic        load_in_plane;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1     <= in_kind;
			row_s1      <= in_row;
			col_s1      <= in_col;
			value_s1    <= in_value[ELEM_BITS-1:0];
			prod_row_s1 <= 28'(in_row) * 28'(cfg.recip_scale_q16);
			prod_col_s1 <= 28'(in_col) * 28'(cfg.recip_scale_q16);
		end
	end

	// Zero acts as one, anything above the store size as the store size.
	always_comb begin
		if (cfg.in_width == 9'd0) begin
			eff_w = 9'd1;
		end else if ({4'b0, cfg.in_width} > MAXW_C) begin
			eff_w = MAXW_C[8:0];
		end else begin
			eff_w = cfg.in_width;
		end
		if (cfg.in_height == 9'd0) begin
			eff_h = 9'd1;
		end else if ({4'b0, cfg.in_height} > MAXH_C) begin
			eff_h = MAXH_C[8:0];
		end else begin
			eff_h = cfg.in_height;
		end
	end

	assign src_row = prod_row_s1[27:16];
	assign src_col = prod_col_s1[27:16];
	assign map_row = (src_row > 12'(eff_h - 9'd1)) ? 12'(eff_h - 9'd1) : src_row;
	assign map_col = (src_col > 12'(eff_w - 9'd1)) ? 12'(eff_w - 9'd1) : src_col;

	assign load_in_plane = ({1'b0, row_s1} < 12'(eff_h)) && ({1'b0, col_s1} < 12'(eff_w));

	assign ram_we    = adv && valid_s1 && (kind_s1 == KIND_LOAD) && load_in_plane;
	assign ram_waddr = AW'(row_s1) * AW'(MAX_WIDTH) + AW'(col_s1);
	assign ram_wdata = value_s1;
	assign ram_re    = adv && valid_s1 && (kind_s1 == KIND_REQUEST);
	assign ram_raddr = AW'(map_row) * AW'(MAX_WIDTH) + AW'(map_col);

endmodule

// ===== src/nur_requant.sv =====
// Back stages: requantizes the element read from the store, or passes it raw in raw mode,
// and holds the result in the output register. Depends on nur_pkg.
module nur_requant #(
	parameter int ELEM_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 rd_valid,
	input  logic [ELEM_BITS-1:0] rd_elem,
	input  nur_pkg::cfg_t        cfg,
	output logic                 out_valid,
	output logic [31:0]          out_value,
	output logic                 out_clamped
);
	import nur_pkg::*;

	logic        valid_s3;
	logic        neg_s3;
	logic [31:0] prod_s3;
	logic [31:0] raw_s3;

	logic        valid_q;
	logic [31:0] value_q;
	logic        clamped_q;

	logic [8:0]         diff;
	logic               neg;
	logic [7:0]         mag;
	logic [32:0]        rnd;
	logic [16:0]        q;
	logic signed [18:0] sval;
	logic [7:0]         qbyte;
	logic               sat;

	assign diff = {1'b0, rd_elem[7:0]} - {1'b0, cfg.in_zero_pt};
	assign neg  = diff[8];
	assign mag  = neg ? 8'(-diff) : diff[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s3 <= rd_valid;
			valid_q  <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s3    <= neg;
			prod_s3   <= 32'(mag) * 32'(cfg.requant_mult_q16);
			raw_s3    <= 32'(rd_elem);
			value_q   <= (cfg.mode == MODE_RAW) ? raw_s3 : {24'b0, qbyte};
			clamped_q <= (cfg.mode == MODE_QUANT) && sat;
		end
	end

	// Round half away from zero on the magnitude, then restore the sign.
	assign rnd  = 33'(prod_s3) + 33'd32768;
	assign q    = rnd[32:16];
	assign sval = (neg_s3 ? -$signed({2'b0, q}) : $signed({2'b0, q}))
	              + $signed({11'b0, cfg.out_zero_pt});

	always_comb begin
		if (sval > $signed(19'(QMAX))) begin
			qbyte = QMAX;
			sat   = 1'b1;
		end else if (sval < 0) begin
			qbyte = 8'd0;
			sat   = 1'b1;
		end else begin
			qbyte = sval[7:0];
			sat   = 1'b0;
		end
	end

	assign out_valid   = valid_q;
	assign out_value   = value_q;
	assign out_clamped = clamped_q;

endmodule
